// ----- src/trfp_pkg.sv -----
// ----------------------------------------------------------------------------
// trfp_pkg
// Shared constants and types of the typed record frame parser.
// ----------------------------------------------------------------------------
package trfp_pkg;

   localparam int unsigned LEN_W = 18;
   localparam logic [LEN_W-1:0] MAX_FRAME_LEN_RESET = 18'd131072;

   localparam logic [3:0] PH_HUNT = 4'd0;
   localparam logic [3:0] PH_LOCK = 4'd1;
   localparam logic [3:0] PH_OPC  = 4'd2;
   localparam logic [3:0] PH_PAR  = 4'd3;
   localparam logic [3:0] PH_OBJ  = 4'd4;
   localparam logic [3:0] PH_ROW  = 4'd5;
   localparam logic [3:0] PH_TAG  = 4'd6;
   localparam logic [3:0] PH_BOOL = 4'd7;
   localparam logic [3:0] PH_INT1 = 4'd8;
   localparam logic [3:0] PH_INTN = 4'd9;
   localparam logic [3:0] PH_LEN  = 4'd10;
   localparam logic [3:0] PH_PAY  = 4'd11;
   localparam logic [3:0] PH_SKIP = 4'd12;

   localparam logic [3:0] KIND_HDR   = 4'd0;
   localparam logic [3:0] KIND_OBJ   = 4'd1;
   localparam logic [3:0] KIND_ROW   = 4'd2;
   localparam logic [3:0] KIND_NULL  = 4'd3;
   localparam logic [3:0] KIND_BOOL  = 4'd4;
   localparam logic [3:0] KIND_INT32 = 4'd5;
   localparam logic [3:0] KIND_INT64 = 4'd6;
   localparam logic [3:0] KIND_BYTES = 4'd7;
   localparam logic [3:0] KIND_PAY   = 4'd8;

   localparam logic [3:0] ERR_NONE  = 4'd0;
   localparam logic [3:0] ERR_FLEN  = 4'd1;
   localparam logic [3:0] ERR_OPC   = 4'd2;
   localparam logic [3:0] ERR_TYPE  = 4'd3;
   localparam logic [3:0] ERR_BLEN  = 4'd4;
   localparam logic [3:0] ERR_BBYTE = 4'd5;
   localparam logic [3:0] ERR_SIZE  = 4'd6;
   localparam logic [3:0] ERR_TRUNC = 4'd7;
   localparam logic [3:0] ERR_AUTH  = 4'd8;
   localparam logic [3:0] ERR_PCNT  = 4'd9;
   localparam logic [3:0] ERR_PNAME = 4'd10;

   localparam logic [2:0] TY_BYTES  = 3'd1;
   localparam logic [2:0] TY_STRING = 3'd2;
   localparam logic [2:0] TY_INT    = 3'd3;
   localparam logic [2:0] TY_LONG   = 3'd4;
   localparam logic [2:0] TY_BOOL   = 3'd5;

   localparam logic [7:0] OPC_AUTH = 8'd1;
   localparam logic [7:0] OPC_PROP = 8'd3;
   localparam logic [7:0] OPC_LIST = 8'd4;

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  opcode;
      logic [7:0]  param;
      logic [63:0] value;
      logic [2:0]  tcode;
      logic [3:0]  err;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [3:0]       phase;
      logic [LEN_W-1:0] frame_left;
      logic [7:0]       field_left;
      logic [63:0]      shift;
      logic [7:0]       opcode;
      logic [7:0]       param;
      logic [7:0]       values_left;
      logic [2:0]       vtype;
      logic [2:0]       first_vtype;
      logic [31:0]      payload_left;
   } state_type;

endpackage

// ----- src/typed_record_frame_parser_unit.sv -----
// ----------------------------------------------------------------------------
// typed_record_frame_parser_unit
// Byte-serial parser for length-framed typed records.
// ----------------------------------------------------------------------------
// Bytes enter on the req_ channel (valid/ready) with a restart flag; each
// byte that completes a token or raises an error yields one result on the
// rsp_ channel (valid/ready). Bytes that complete nothing yield no result.
// One byte is taken every cycle while req_ready is high, and its result is
// registered. The decode of a byte is a single pass of logic between the
// parser state registers and the result register.
// While a result waits on a stalled receiver, bytes are still taken and the
// next result is held in a skid register; req_ready falls only when both
// are full. Reset empties both registers, sets the frame length limit to
// its default and puts the parser in search of a length header.
// csr_we with csr_wdata writes the frame length limit; write it only while
// the parser is idle.
// ----------------------------------------------------------------------------
module typed_record_frame_parser_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [17:0]  csr_wdata,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_data_byte,
   input  logic         req_restart,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [3:0]   rsp_token_kind,
   output logic [7:0]   rsp_opcode,
   output logic [7:0]   rsp_param_byte,
   output logic signed [63:0] rsp_value,
   output logic [2:0]   rsp_type_code,
   output logic [3:0]   rsp_error_code,
   output logic         rsp_frame_end
);

   trfp_pkg::state_type  st_ff, st_in;
   trfp_pkg::result_type out_ff, skid_ff, res;
   logic                 out_v_ff, skid_v_ff, emit, acc;
   logic [17:0]          max_ff;

   trfp_step u_step (
      .cur(st_ff), .data_byte(req_data_byte), .restart(req_restart),
      .max_len(max_ff), .nxt(st_in), .emit(emit), .res(res)
   );

   assign req_ready = !skid_v_ff;
   assign acc = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
         max_ff <= trfp_pkg::MAX_FRAME_LEN_RESET;
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (csr_we) max_ff <= csr_wdata;
         if (acc) st_ff <= st_in;
         if (!out_v_ff || rsp_ready) begin
            if (skid_v_ff) begin
               out_ff <= skid_ff;
               out_v_ff <= 1'b1;
               skid_v_ff <= 1'b0;
            end else begin
               out_ff <= res;
               out_v_ff <= acc && emit;
            end
         end else if (acc && emit) begin
            skid_ff <= res;
            skid_v_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_token_kind = out_ff.kind;
   assign rsp_opcode = out_ff.opcode;
   assign rsp_param_byte = out_ff.param;
   assign rsp_value = out_ff.value;
   assign rsp_type_code = out_ff.tcode;
   assign rsp_error_code = out_ff.err;
   assign rsp_frame_end = out_ff.last;

`ifndef SYNTHESIS
   a_skid_only_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff) else $error("skid holds data with output empty");
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> !req_ready) else $error("ready while skid full");
   a_lock_stays: assert property (@(posedge clock) disable iff (reset)
      (st_ff.phase == trfp_pkg::PH_LOCK && !(acc && req_restart))
      |=> st_ff.phase == trfp_pkg::PH_LOCK) else $error("lock left without restart");
`endif

endmodule

// ----- src/trfp_step.sv -----
// ----------------------------------------------------------------------------
// trfp_step
// Combinational next-state and token logic for one received byte.
// ----------------------------------------------------------------------------
module trfp_step (
   input  trfp_pkg::state_type            cur,
   input  logic [7:0]                     data_byte,
   input  logic                           restart,
   input  logic [trfp_pkg::LEN_W-1:0]     max_len,
   output trfp_pkg::state_type            nxt,
   output logic                           emit,
   output trfp_pkg::result_type           res
);

   localparam int LEN_W_L = trfp_pkg::LEN_W;

   logic [3:0]  ph, kind, err;
   logic        tok, last;
   logic [2:0]  tcode, ty;
   logic [63:0] val, sh, id;
   logic [7:0]  fl, ln, vl;
   logic [31:0] len;
   logic [LEN_W_L-1:0] fr;

   function automatic logic [3:0] fin_chk(input logic [7:0] op, input logic [7:0] pa,
                                          input logic [2:0] fv);
      logic [3:0] e;
      e = trfp_pkg::ERR_NONE;
      if (op == trfp_pkg::OPC_AUTH && pa == 8'd1 && fv != trfp_pkg::TY_BYTES)
         e = trfp_pkg::ERR_AUTH;
      else if (op == trfp_pkg::OPC_PROP) begin
         if (pa != 8'd2) e = trfp_pkg::ERR_PCNT;
         else if (fv != trfp_pkg::TY_STRING) e = trfp_pkg::ERR_PNAME;
      end
      return e;
   endfunction

   always_comb begin
      nxt  = cur;
      res  = '0;
      tok  = 1'b0;
      last = 1'b0;
      kind = trfp_pkg::KIND_HDR;
      err  = trfp_pkg::ERR_NONE;
      tcode = 3'd0;
      val  = 64'd0;
      ty   = data_byte[6:4];
      ln   = data_byte & 8'h8F;
      sh   = 64'd0;
      fl   = 8'd0;
      len  = 32'd0;
      id   = 64'd0;
      vl   = 8'd0;
      fr   = '0;
      ph   = cur.phase;
      emit = 1'b0;
      if (restart) begin
         nxt.phase = trfp_pkg::PH_HUNT;
         nxt.field_left = 8'd0;
         nxt.shift = 64'd0;
         nxt.frame_left = '0;
      end else if (cur.phase == trfp_pkg::PH_LOCK) begin
         nxt = cur;
      end else if (cur.phase == trfp_pkg::PH_HUNT || cur.frame_left == '0) begin
         sh = (cur.phase == trfp_pkg::PH_HUNT) ? cur.shift : 64'd0;
         fl = (cur.phase == trfp_pkg::PH_HUNT) ? cur.field_left : 8'd0;
         nxt.phase = trfp_pkg::PH_HUNT;
         len = {sh[23:0], data_byte};
         fl = fl + 8'd1;
         nxt.shift = {32'd0, len};
         nxt.field_left = fl;
         if (fl >= 8'd4) begin
            nxt.field_left = 8'd0;
            nxt.shift = 64'd0;
            if (len != 32'd0) begin
               if (len[31] || len > {14'd0, max_len}) begin
                  nxt.phase = trfp_pkg::PH_LOCK;
                  emit = 1'b1;
                  res.kind = trfp_pkg::KIND_HDR;
                  res.opcode = 8'd0;
                  res.param = 8'd0;
                  res.value = {{32{len[31]}}, len};
                  res.tcode = 3'd0;
                  res.err = trfp_pkg::ERR_FLEN;
                  res.last = 1'b0;
               end else begin
                  nxt.frame_left = len[LEN_W_L-1:0];
                  nxt.phase = trfp_pkg::PH_OPC;
               end
            end
         end
      end else begin
         fr = cur.frame_left - LEN_W_L'(1);
         nxt.frame_left = fr;
         last = (fr == '0);
         case (cur.phase)
            trfp_pkg::PH_OPC: begin
               nxt.opcode = data_byte;
               nxt.param = 8'd0;
               if (data_byte < 8'd1 || data_byte > 8'd4) begin
                  err = trfp_pkg::ERR_OPC;
                  val = {56'd0, data_byte};
               end else nxt.phase = trfp_pkg::PH_PAR;
            end
            trfp_pkg::PH_PAR: begin
               nxt.param = data_byte;
               nxt.values_left = data_byte;
               tok = 1'b1;
               if (cur.opcode == trfp_pkg::OPC_AUTH) begin
                  if (data_byte == 8'd0) begin
                     nxt.phase = trfp_pkg::PH_OPC;
                     err = fin_chk(cur.opcode, data_byte, cur.first_vtype);
                  end else nxt.phase = trfp_pkg::PH_TAG;
               end else begin
                  nxt.phase = trfp_pkg::PH_OBJ;
                  nxt.field_left = 8'd0;
                  nxt.shift = 64'd0;
               end
            end
            trfp_pkg::PH_OBJ, trfp_pkg::PH_ROW: begin
               sh = {32'd0, cur.shift[23:0], data_byte};
               fl = cur.field_left + 8'd1;
               nxt.shift = sh;
               nxt.field_left = fl;
               if ((fl == 8'd2 && !sh[15]) || fl >= 8'd4) begin
                  id = (fl >= 8'd4) ? {33'd0, sh[30:0]} : sh;
                  tok = 1'b1;
                  val = id;
                  kind = (cur.phase == trfp_pkg::PH_OBJ) ? trfp_pkg::KIND_OBJ
                                                         : trfp_pkg::KIND_ROW;
                  nxt.field_left = 8'd0;
                  nxt.shift = 64'd0;
                  vl = cur.values_left;
                  if (cur.phase == trfp_pkg::PH_OBJ && cur.opcode == trfp_pkg::OPC_LIST
                      && cur.param == 8'hFF) begin
                     nxt.phase = trfp_pkg::PH_OPC;
                     err = fin_chk(cur.opcode, cur.param, cur.first_vtype);
                  end else if (cur.phase == trfp_pkg::PH_OBJ
                               && cur.opcode == trfp_pkg::OPC_LIST) begin
                     if (cur.param == 8'hFE) nxt.values_left = 8'd0;
                     nxt.phase = trfp_pkg::PH_ROW;
                  end else if (vl == 8'd0) begin
                     nxt.phase = trfp_pkg::PH_OPC;
                     err = fin_chk(cur.opcode, cur.param, cur.first_vtype);
                  end else nxt.phase = trfp_pkg::PH_TAG;
               end
            end
            trfp_pkg::PH_TAG: begin
               if (cur.values_left == cur.param) nxt.first_vtype = ty;
               nxt.vtype = ty;
               tcode = ty;
               if (ty == trfp_pkg::TY_BOOL || (ty >= 3'd1 && ty <= 3'd4)) begin
                  if (ln == 8'd0) begin
                     tok = 1'b1;
                     kind = trfp_pkg::KIND_NULL;
                     ph = trfp_pkg::PH_PAY;
                  end else if (ty == trfp_pkg::TY_BOOL) begin
                     if (ln == 8'd1) nxt.phase = trfp_pkg::PH_BOOL;
                     else begin
                        err = trfp_pkg::ERR_BLEN;
                        val = {56'd0, data_byte};
                     end
                  end else begin
                     nxt.field_left = ln;
                     nxt.shift = 64'd0;
                     nxt.phase = (ty <= 3'd2) ? trfp_pkg::PH_LEN : trfp_pkg::PH_INT1;
                  end
               end else begin
                  err = trfp_pkg::ERR_TYPE;
                  val = {56'd0, data_byte};
               end
            end
            trfp_pkg::PH_BOOL: begin
               tcode = cur.vtype;
               if (data_byte == 8'hFF || data_byte == 8'h00) begin
                  tok = 1'b1;
                  kind = trfp_pkg::KIND_BOOL;
                  val = {63'd0, data_byte != 8'h00};
                  ph = trfp_pkg::PH_PAY;
               end else begin
                  err = trfp_pkg::ERR_BBYTE;
                  val = {56'd0, data_byte};
               end
            end
            trfp_pkg::PH_INT1, trfp_pkg::PH_INTN: begin
               tcode = cur.vtype;
               sh = (cur.phase == trfp_pkg::PH_INT1) ? {{56{data_byte[7]}}, data_byte}
                                                     : {cur.shift[55:0], data_byte};
               nxt.shift = sh;
               fl = cur.field_left - 8'd1;
               nxt.field_left = fl;
               nxt.phase = trfp_pkg::PH_INTN;
               if (fl == 8'd0) begin
                  tok = 1'b1;
                  if (cur.vtype == trfp_pkg::TY_INT) begin
                     kind = trfp_pkg::KIND_INT32;
                     val = {{32{sh[31]}}, sh[31:0]};
                  end else begin
                     kind = trfp_pkg::KIND_INT64;
                     val = sh;
                  end
                  ph = trfp_pkg::PH_PAY;
               end
            end
            trfp_pkg::PH_LEN: begin
               tcode = cur.vtype;
               sh = {32'd0, cur.shift[23:0], data_byte};
               nxt.shift = sh;
               fl = cur.field_left - 8'd1;
               nxt.field_left = fl;
               if (fl == 8'd0) begin
                  if (sh[31:0] >= {14'd0, max_len}) begin
                     err = trfp_pkg::ERR_SIZE;
                     val = sh;
                  end else begin
                     tok = 1'b1;
                     kind = trfp_pkg::KIND_BYTES;
                     val = sh;
                     nxt.payload_left = sh[31:0];
                     if (sh[31:0] == 32'd0) ph = trfp_pkg::PH_PAY;
                     else nxt.phase = trfp_pkg::PH_PAY;
                  end
               end
            end
            trfp_pkg::PH_PAY: begin
               tcode = cur.vtype;
               tok = 1'b1;
               kind = trfp_pkg::KIND_PAY;
               val = {56'd0, data_byte};
               nxt.payload_left = cur.payload_left - 32'd1;
               if (cur.payload_left == 32'd1) ph = trfp_pkg::PH_PAY;
               else ph = trfp_pkg::PH_SKIP;
            end
            default: ph = trfp_pkg::PH_SKIP;
         endcase
         // A completed value: count it down and move on.
         if (ph == trfp_pkg::PH_PAY && cur.phase != trfp_pkg::PH_PAY
             || (cur.phase == trfp_pkg::PH_PAY && ph == trfp_pkg::PH_PAY)) begin
            vl = cur.values_left - 8'd1;
            nxt.values_left = vl;
            if (vl == 8'd0) begin
               nxt.phase = trfp_pkg::PH_OPC;
               err = fin_chk(cur.opcode, cur.param,
                             (cur.phase == trfp_pkg::PH_TAG && cur.values_left == cur.param)
                             ? ty : cur.first_vtype);
            end else nxt.phase = trfp_pkg::PH_TAG;
         end
         if (last) begin
            if (err == trfp_pkg::ERR_NONE && nxt.phase != trfp_pkg::PH_OPC
                && nxt.phase != trfp_pkg::PH_SKIP) begin
               err = trfp_pkg::ERR_TRUNC;
            end
            nxt.phase = trfp_pkg::PH_HUNT;
            nxt.field_left = 8'd0;
            nxt.shift = 64'd0;
         end else if (err != trfp_pkg::ERR_NONE) begin
            nxt.phase = trfp_pkg::PH_SKIP;
         end
         if (err != trfp_pkg::ERR_NONE) begin
            if (err >= trfp_pkg::ERR_TRUNC || err <= trfp_pkg::ERR_OPC) tcode = 3'd0;
            if (err >= trfp_pkg::ERR_TRUNC) val = 64'd0;
            kind = trfp_pkg::KIND_HDR;
            tok = 1'b1;
         end
         emit = tok;
         res.kind = kind;
         res.opcode = nxt.opcode;
         res.param = nxt.param;
         res.value = val;
         res.tcode = tcode;
         res.err = err;
         res.last = last;
      end
      if (!emit) res = '0;
   end

endmodule
